FILE: rtl/assert_macros.svh
// assertion macros used by the top level rtl file of the encoder limit block
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/jaenc_pkg.sv
// types, constants and helper functions for the joint angle to encoder limit block
// depends on nothing; imported by jaenc_scale, jaenc_limit and the top level
package jaenc_pkg;

	// stream widths
	localparam int unsigned S_TDATA_W = 96;
	localparam int unsigned M_TDATA_W = 96;
	localparam int unsigned M_TUSER_W = 1;

	// channel datapath widths
	localparam int unsigned NUM_CH = 7;
	localparam int unsigned NUM_W  = 27;
	localparam int unsigned RCP_W  = 28;
	localparam int unsigned Q_W    = 14;

	typedef enum logic [2:0] {
		CH_LIFT,
		CH_SHLD,
		CH_ELB,
		CH_YAW,
		CH_W1,
		CH_W2,
		CH_GRP
	} chan_t;

	// reduced ratios: count = trunc(N * x / D)
	localparam logic signed [27:0] LIFT_N   = 28'sd1739;
	localparam logic signed [27:0] LIFT_OFS = 28'sd14800;
	localparam logic signed [27:0] SHLD_N   = 28'sd263;
	localparam logic signed [27:0] ELB_N    = 28'sd1209;
	localparam logic signed [27:0] YAW_N    = 28'sd1071;
	localparam logic signed [27:0] W1_N     = 28'sd1375;
	localparam logic signed [27:0] W2_N     = 28'sd4221;
	localparam logic signed [27:0] GRP_N    = 28'sd41;
	localparam logic signed [27:0] GRP_OFS  = 28'sd1440;

	// reciprocals ceil(2^k / d), k = numerator bits + ceil(log2 d) keeps them exact
	localparam logic [63:0] LIFT_M = ((64'd1 << 39) + 64'd7399) / 64'd7400;
	localparam logic [63:0] SHLD_M = ((64'd1 << 29) + 64'd143) / 64'd144;
	localparam logic [63:0] ELB_M  = ((64'd1 << 34) + 64'd1323) / 64'd1324;
	localparam logic [63:0] YAW_M  = ((64'd1 << 36) + 64'd3519) / 64'd3520;
	localparam logic [63:0] W1_M   = ((64'd1 << 35) + 64'd1631) / 64'd1632;
	localparam logic [63:0] W2_M   = ((64'd1 << 39) + 64'd5007) / 64'd5008;
	localparam logic [63:0] GRP_M  = ((64'd1 << 23) + 64'd47) / 64'd48;

	localparam logic [RCP_W-1:0] DIV_M [NUM_CH] = '{
		RCP_W'(LIFT_M), RCP_W'(SHLD_M), RCP_W'(ELB_M), RCP_W'(YAW_M),
		RCP_W'(W1_M), RCP_W'(W2_M), RCP_W'(GRP_M)
	};
	localparam logic [5:0] DIV_K [NUM_CH] = '{
		6'd39, 6'd29, 6'd34, 6'd36, 6'd35, 6'd39, 6'd23
	};

	// divide by three for the yaw limit shift
	localparam logic [63:0] THIRD_M64 = ((64'd1 << 14) + 64'd2) / 64'd3;
	localparam logic [12:0] THIRD_M   = 13'(THIRD_M64);
	localparam logic [3:0]  THIRD_K   = 4'd14;

	// clamp bounds
	localparam logic signed [13:0] LIFT_LO  = -14'sd3478;
	localparam logic signed [13:0] LIFT_HI  = -14'sd20;
	localparam logic signed [13:0] SHLD_LO  = -14'sd2630;
	localparam logic signed [13:0] SHLD_HI  = 14'sd2630;
	localparam logic signed [13:0] ELB_LO   = -14'sd2630;
	localparam logic signed [13:0] ELB_HI   = 14'sd2206;
	localparam logic signed [13:0] GRP_LO   = -14'sd30;
	localparam logic signed [13:0] GRP_HI   = 14'sd1200;
	localparam logic signed [13:0] YAW_SPAN = 14'sd1071;

	// wrist window on sum and difference
	localparam logic signed [14:0] SUM_MIN = -15'sd2642;
	localparam logic signed [14:0] SUM_MAX = 15'sd108;
	localparam logic signed [14:0] DIF_MIN = -15'sd3560;
	localparam logic signed [14:0] DIF_MAX = 15'sd4882;

	typedef struct packed {
		logic signed [14:0] lift_height;
		logic signed [12:0] shoulder_angle;
		logic signed [12:0] elbow_angle;
		logic signed [12:0] yaw_angle;
		logic signed [12:0] pitch_angle;
		logic signed [12:0] roll_angle;
		logic signed [11:0] gripper_opening;
	} pose_t;

	// sign and magnitude of one scaled numerator
	typedef struct packed {
		logic             neg;
		logic [NUM_W-1:0] mag;
	} num_t;

	// per-stage load strobes from the top level flow control
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} stage_ld_t;

	typedef struct packed {
		logic signed [12:0] lift_count;
		logic signed [12:0] shoulder_count;
		logic signed [12:0] elbow_count;
		logic signed [11:0] yaw_count;
		logic signed [12:0] wrist_one_count;
		logic signed [12:0] wrist_two_count;
		logic signed [11:0] gripper_count;
		logic               wrist_zeroed;
	} res_t;

	function automatic num_t to_num(input logic signed [27:0] n);
		num_t r;
		r.neg = n[27];
		r.mag = NUM_W'(n[27] ? -n : n);
		return r;
	endfunction

	// floor(mag / d) by multiply with the reciprocal and shift
	function automatic logic [Q_W-1:0] recip_div(input logic [NUM_W-1:0] mag,
			input logic [RCP_W-1:0] m, input logic [5:0] k);
		logic [54:0] prod;
		prod = 55'(mag) * 55'(m);
		return Q_W'(prod >> k);
	endfunction

	function automatic logic signed [13:0] clamp14(input logic signed [13:0] v,
			input logic signed [13:0] lo, input logic signed [13:0] hi);
		logic signed [13:0] r;
		priority if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: rtl/joint_angle_to_encoder_limit_unit.sv
// top level of the joint angle to encoder limit block: stream ports, flow control
// depends on jaenc_pkg, jaenc_scale, jaenc_limit and assert_macros.svh
//
// Converts one arm pose per input word into seven encoder setpoints and a wrist flag.
// Input channel s_*: one pose per word, all fields signed with 4 fraction bits.
// Output channel m_*: one setpoint word per pose, in the order the poses came in.
// On its way to m_tvalid the word passes five registers (input register, scaled
// numerators, reciprocal divide, clamps and wrist window, yaw clamp in the result
// register).
// Throughput: one word per cycle while m_tready stays high; every stage is a
// register with its own valid bit, so bubbles close up.
// When the receiver stalls, the result waits in the output register and the stages
// behind it keep filling; s_tready falls only once all five stages hold a word.
// Reset clears every valid bit, so no word is shown after reset until one is fed in.
// There is no configuration and no state carried from one pose to the next.
`include "assert_macros.svh"

module joint_angle_to_encoder_limit_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// lift_height[14:0], shoulder_angle[27:15], elbow_angle[40:28], yaw_angle[53:41],
	// pitch_angle[66:54], roll_angle[79:67], gripper_opening[91:80], zero above
	input  logic [jaenc_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// lift_count[12:0], shoulder_count[25:13], elbow_count[38:26], yaw_count[50:39],
	// wrist_one_count[63:51], wrist_two_count[76:64], gripper_count[88:77], zero above
	output logic [jaenc_pkg::M_TDATA_W-1:0]   m_tdata,
	// wrist_zeroed[0]
	output logic [jaenc_pkg::M_TUSER_W-1:0]   m_tuser
);
	import jaenc_pkg::*;

	logic      v_s1;
	logic      v_s2;
	logic      v_s3;
	logic      v_s4;
	logic      v_s5;
	logic      rdy_s1;
	logic      rdy_s2;
	logic      rdy_s3;
	logic      rdy_s4;
	logic      rdy_s5;
	logic      ld_s1;
	stage_ld_t ld;
	pose_t     pose_d;
	pose_t     pose_s1;
	logic [NUM_CH-1:0][Q_W-1:0] quot_s3;
	res_t      res_s5;

	// a stage takes a word when it is empty or its word moves on
	assign rdy_s5 = ~v_s5 | m_tready;
	assign rdy_s4 = ~v_s4 | rdy_s5;
	assign rdy_s3 = ~v_s3 | rdy_s4;
	assign rdy_s2 = ~v_s2 | rdy_s3;
	assign rdy_s1 = ~v_s1 | rdy_s2;

	assign ld_s1    = rdy_s1 & s_tvalid;
	assign ld.ld_s2 = rdy_s2 & v_s1;
	assign ld.ld_s3 = rdy_s3 & v_s2;
	assign ld.ld_s4 = rdy_s4 & v_s3;
	assign ld.ld_s5 = rdy_s5 & v_s4;

	assign s_tready = rdy_s1;
	assign m_tvalid = v_s5;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// unpack the input word
	always_comb begin
		pose_d.lift_height     = s_tdata[14:0];
		pose_d.shoulder_angle  = s_tdata[27:15];
		pose_d.elbow_angle     = s_tdata[40:28];
		pose_d.yaw_angle       = s_tdata[53:41];
		pose_d.pitch_angle     = s_tdata[66:54];
		pose_d.roll_angle      = s_tdata[79:67];
		pose_d.gripper_opening = s_tdata[91:80];
	end

	// input register
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			pose_s1 <= pose_d;
		end
	end

	jaenc_scale u_scale (
		.clk     (clk),
		.ld      (ld),
		.pose_s1 (pose_s1),
		.quot_s3 (quot_s3)
	);

	jaenc_limit u_limit (
		.clk     (clk),
		.ld      (ld),
		.quot_s3 (quot_s3),
		.res_s5  (res_s5)
	);

	// pack the output word
	assign m_tdata = {
		7'd0,
		res_s5.gripper_count,
		res_s5.wrist_two_count,
		res_s5.wrist_one_count,
		res_s5.yaw_count,
		res_s5.elbow_count,
		res_s5.shoulder_count,
		res_s5.lift_count
	};
	assign m_tuser = res_s5.wrist_zeroed;

	// checks
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_tvalid && s_tready, v_s1, "accepted word missing from input stage")
	`ASSERT_NEXT(a_stall_keeps_s4, clk, arst_n, v_s4 && v_s5 && !m_tready, v_s4, "word lost behind stalled output")
	`ASSERT_IMPL(a_wrist_zero, clk, arst_n, m_tvalid && res_s5.wrist_zeroed, res_s5.wrist_one_count == 13'sd0 && res_s5.wrist_two_count == 13'sd0, "wrist flagged but counts not zero")
	`ASSERT_IMPL(a_lift_range, clk, arst_n, m_tvalid, res_s5.lift_count >= LIFT_LO && res_s5.lift_count <= LIFT_HI, "lift count outside its range")

endmodule

FILE: rtl/jaenc_scale.sv
// scaling stages: scaled numerators, then exact truncating division per channel
// depends on jaenc_pkg
module jaenc_scale (
	input  logic                                                 clk,
	input  jaenc_pkg::stage_ld_t                                 ld,
	input  jaenc_pkg::pose_t                                     pose_s1,
	output logic [jaenc_pkg::NUM_CH-1:0][jaenc_pkg::Q_W-1:0]     quot_s3
);
	import jaenc_pkg::*;

	logic signed [27:0] lift_x;
	logic signed [27:0] shld_x;
	logic signed [27:0] elb_x;
	logic signed [27:0] yaw_x;
	logic signed [27:0] pitch_x;
	logic signed [27:0] roll_x;
	logic signed [27:0] grp_x;
	num_t [NUM_CH-1:0]  num_d;
	num_t [NUM_CH-1:0]  num_s2;
	logic [NUM_CH-1:0][Q_W-1:0] qmag_d;
	logic [NUM_CH-1:0][Q_W-1:0] quot_d;

	// widen the pose fields
	assign lift_x  = 28'(pose_s1.lift_height);
	assign shld_x  = 28'(pose_s1.shoulder_angle);
	assign elb_x   = 28'(pose_s1.elbow_angle);
	assign yaw_x   = 28'(pose_s1.yaw_angle);
	assign pitch_x = 28'(pose_s1.pitch_angle);
	assign roll_x  = 28'(pose_s1.roll_angle);
	assign grp_x   = 28'(pose_s1.gripper_opening);

	// numerators including offsets, split into sign and magnitude
	always_comb begin
		num_d[CH_LIFT] = to_num((lift_x - LIFT_OFS) * LIFT_N);
		num_d[CH_SHLD] = to_num(shld_x * SHLD_N);
		num_d[CH_ELB]  = to_num(elb_x * ELB_N);
		num_d[CH_YAW]  = to_num(((yaw_x <<< 1) + elb_x) * YAW_N);
		num_d[CH_W1]   = to_num((roll_x + pitch_x) * W1_N);
		num_d[CH_W2]   = to_num((pitch_x - roll_x) * W2_N);
		num_d[CH_GRP]  = to_num(grp_x * GRP_N - GRP_OFS);
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s2) begin
			num_s2 <= num_d;
		end
	end

	// reciprocal divide of the magnitude, sign restored for truncation toward zero
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			qmag_d[3'(i)] = recip_div(num_s2[3'(i)].mag, DIV_M[3'(i)], DIV_K[3'(i)]);
			quot_d[3'(i)] = num_s2[3'(i)].neg ? (Q_W'(0) - qmag_d[3'(i)]) : qmag_d[3'(i)];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			quot_s3 <= quot_d;
		end
	end

endmodule

FILE: rtl/jaenc_limit.sv
// limit stages: range clamps, wrist window, elbow-dependent yaw window
// depends on jaenc_pkg
module jaenc_limit (
	input  logic                                             clk,
	input  jaenc_pkg::stage_ld_t                             ld,
	input  logic [jaenc_pkg::NUM_CH-1:0][jaenc_pkg::Q_W-1:0] quot_s3,
	output jaenc_pkg::res_t                                  res_s5
);
	import jaenc_pkg::*;

	logic signed [13:0] q_lift;
	logic signed [13:0] q_shld;
	logic signed [13:0] q_elb;
	logic signed [13:0] q_yaw;
	logic signed [13:0] q_w1;
	logic signed [13:0] q_w2;
	logic signed [13:0] q_grp;
	logic signed [13:0] c_lift;
	logic signed [13:0] c_shld;
	logic signed [13:0] c_elb;
	logic signed [13:0] c_grp;
	logic signed [14:0] w_sum;
	logic signed [14:0] w_dif;
	logic               win_bad;
	logic               elb_neg;
	logic [11:0]        elb_mag;
	logic [25:0]        lim_prod;
	logic [9:0]         lim_mag;
	logic signed [10:0] lim_d;

	logic signed [12:0] lift_s4;
	logic signed [12:0] shld_s4;
	logic signed [12:0] elb_s4;
	logic signed [12:0] yaw_s4;
	logic signed [12:0] w1_s4;
	logic signed [12:0] w2_s4;
	logic signed [11:0] grp_s4;
	logic               zero_s4;
	logic signed [10:0] lim_s4;

	logic signed [13:0] yaw_lo;
	logic signed [13:0] yaw_hi;
	logic signed [13:0] c_yaw;

	assign q_lift = $signed(quot_s3[CH_LIFT]);
	assign q_shld = $signed(quot_s3[CH_SHLD]);
	assign q_elb  = $signed(quot_s3[CH_ELB]);
	assign q_yaw  = $signed(quot_s3[CH_YAW]);
	assign q_w1   = $signed(quot_s3[CH_W1]);
	assign q_w2   = $signed(quot_s3[CH_W2]);
	assign q_grp  = $signed(quot_s3[CH_GRP]);

	// fixed range clamps
	assign c_lift = clamp14(q_lift, LIFT_LO, LIFT_HI);
	assign c_shld = clamp14(q_shld, SHLD_LO, SHLD_HI);
	assign c_elb  = clamp14(q_elb, ELB_LO, ELB_HI);
	assign c_grp  = clamp14(q_grp, GRP_LO, GRP_HI);

	// wrist window on sum and difference of the raw wrist counts
	assign w_sum   = 15'(q_w1) + 15'(q_w2);
	assign w_dif   = 15'(q_w1) - 15'(q_w2);
	assign win_bad = (w_sum > SUM_MAX) || (w_sum < SUM_MIN) ||
		(w_dif > DIF_MAX) || (w_dif < DIF_MIN);

	// clamped elbow over three, truncated toward zero
	assign elb_neg  = c_elb[13];
	assign elb_mag  = 12'(elb_neg ? -c_elb : c_elb);
	assign lim_prod = 26'(elb_mag) * 26'(THIRD_M);
	assign lim_mag  = 10'(lim_prod >> THIRD_K);
	assign lim_d    = elb_neg ? (11'sd0 - $signed(11'(lim_mag))) : $signed(11'(lim_mag));

	always_ff @(posedge clk) begin
		if (ld.ld_s4) begin
			lift_s4 <= c_lift[12:0];
			shld_s4 <= c_shld[12:0];
			elb_s4  <= c_elb[12:0];
			yaw_s4  <= q_yaw[12:0];
			w1_s4   <= win_bad ? 13'sd0 : q_w1[12:0];
			w2_s4   <= win_bad ? 13'sd0 : q_w2[12:0];
			grp_s4  <= c_grp[11:0];
			zero_s4 <= win_bad;
			lim_s4  <= lim_d;
		end
	end

	// yaw window moves with the elbow
	assign yaw_lo = 14'(lim_s4) - YAW_SPAN;
	assign yaw_hi = 14'(lim_s4) + YAW_SPAN;
	assign c_yaw  = clamp14(14'(yaw_s4), yaw_lo, yaw_hi);

	// result register
	always_ff @(posedge clk) begin
		if (ld.ld_s5) begin
			res_s5.lift_count      <= lift_s4;
			res_s5.shoulder_count  <= shld_s4;
			res_s5.elbow_count     <= elb_s4;
			res_s5.yaw_count       <= c_yaw[11:0];
			res_s5.wrist_one_count <= w1_s4;
			res_s5.wrist_two_count <= w2_s4;
			res_s5.gripper_count   <= grp_s4;
			res_s5.wrist_zeroed    <= zero_s4;
		end
	end

endmodule
